// ----- hdl/icx_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// icx_pkg: shared types and functions for the image checksum block
// Checksum mode codes, the reflected CRC-32 byte step and the byte swap.
// ---------------------------------------------------------------------------
package icx_pkg;

    // Reflected CRC-32 polynomial
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Bytes per stream word
    localparam int unsigned WORD_BYTES = 4;

    // Checksum mode register codes
    typedef enum logic {
        MODE_XOR = 1'b0,
        MODE_CRC = 1'b1
    } mode_t;

    // One byte through the reflected CRC, on the non-inverted register
    function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
                                                  input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Reverse the byte order of a word
    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ----- hdl/icx_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// icx_if: request channels of the image checksum block
// Stream word input, checksum output and checksum mode write channel.
// ---------------------------------------------------------------------------

// Image word stream
interface icx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;

    modport source (output valid, output data_word, output byte_count,
                    output last_item, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input last_item, output ready);
endinterface

// Finished checksum
interface icx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

// Checksum mode register write
interface icx_cfg_if;
    logic valid;
    logic ready;
    logic checksum_mode;

    modport source (output valid, output checksum_mode, input ready);
    modport sink   (input valid, input checksum_mode, output ready);
endinterface

// ----- hdl/image_checksum_xor_or_crc32.sv -----
`timescale 1ns / 1ps
// After the last word's request is taken, the result request is offered from the
// result register once the result slot is free. Throughput: one word per cycle, a
// last word waiting while the result slot is full; the input register, one unrolled
// four-byte CRC/XOR update and the result register form the whole path.
// Reset (rst_n low, asynchronous): running value cleared, mode set to XOR,
// all valid flags cleared.
// ---------------------------------------------------------------------------
// image_checksum_xor_or_crc32: streaming image checksum
// Word XOR (mode 0) or reflected CRC-32 over valid bytes (mode 1); the
// checksum is issued on the last word and the running value cleared.
// ---------------------------------------------------------------------------
module image_checksum_xor_or_crc32
    import icx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    icx_cfg_if.sink   cfg,
    icx_in_if.sink    image,
    icx_out_if.source result
);

    // Input register
    logic        s1_valid_reg;
    logic [31:0] s1_word_reg;
    logic [2:0]  s1_count_reg;
    logic        s1_last_reg;

    // State and result register
    mode_t       mode_reg;
    logic [31:0] run_reg;
    logic        out_valid_reg;
    logic [31:0] out_sum_reg;

    logic        s1_fire;
    logic [31:0] sum_next;
    logic [31:0] crc_c;

    // Handshakes: a non-last word needs no result slot
    assign s1_fire     = s1_valid_reg &&
                         (!s1_last_reg || !out_valid_reg || result.ready);
    assign image.ready = !s1_valid_reg || s1_fire;
    assign cfg.ready   = 1'b1;

    assign result.valid    = out_valid_reg;
    assign result.checksum = out_sum_reg;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_XOR;
        else if (cfg.valid)
            mode_reg <= mode_t'(cfg.checksum_mode);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (image.ready)
            s1_valid_reg <= image.valid;
    end

    always_ff @(posedge clk)
    begin
        if (image.valid && image.ready)
        begin
            s1_word_reg  <= image.data_word;
            s1_count_reg <= image.byte_count;
            s1_last_reg  <= image.last_item;
        end
    end

    // Running value update: full-word XOR, or CRC over lanes below the count
    always_comb
    begin
        crc_c = ~run_reg;
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            if (s1_count_reg > 3'(i))
                crc_c = crc_byte_step(crc_c, s1_word_reg[8*i +: 8]);
        end
        case (mode_reg)
            MODE_XOR: sum_next = (s1_count_reg >= 3'(WORD_BYTES)) ?
                                 (run_reg ^ s1_word_reg) : run_reg;
            MODE_CRC: sum_next = ~crc_c;
            default:  sum_next = run_reg;
        endcase
    end

    // Running value and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
                run_reg <= s1_last_reg ? 32'd0 : sum_next;

            if (s1_fire && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result data: CRC goes out byte-swapped
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
            out_sum_reg <= (mode_reg == MODE_CRC) ? swap32(sum_next) : sum_next;
    end

endmodule

// ----- verif/image_checksum_xor_or_crc32_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// image_checksum_xor_or_crc32_tb: checksum block testbench
// Streams image words with random bursts and gaps. The output side stalls on
// its own pattern, and once for a long hold-off. A scoreboard keeps its own
// XOR / CRC-32 running value and checks every issued checksum in order.
// ---------------------------------------------------------------------------
module image_checksum_xor_or_crc32_tb;
    import icx_pkg::*;

    // Scoreboard: running checksum per mode and the queue of due checksums
    class checksum_scoreboard;
        mode_t       mode;
        logic [31:0] running;
        logic [31:0] due_sums[$];
        int unsigned errors;
        int unsigned words_seen;
        int unsigned sums_checked;
        int unsigned xor_sums;
        int unsigned crc_sums;

        function new();
            mode = MODE_XOR;
            running = '0;
            errors = 0;
            words_seen = 0;
            sums_checked = 0;
            xor_sums = 0;
            crc_sums = 0;
        endfunction

        function void set_mode(mode_t m);
            mode = m;
        endfunction

        // Running value always holds the finished CRC, so invert on each side
        function logic [31:0] crc_add_byte(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = ~crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return ~c;
        endfunction

        // Note an accepted word request
        function void note_word(logic [31:0] w, logic [2:0] cnt, logic lst);
            int unsigned n;
            n = (cnt > 3'd4) ? 4 : cnt;
            words_seen++;
            if (mode == MODE_XOR)
            begin
                // partial words are dropped
                if (n == 4)
                    running ^= w;
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    running = crc_add_byte(running, w[8*i +: 8]);
            end
            if (lst)
            begin
                if (mode == MODE_CRC)
                begin
                    due_sums.push_back({running[7:0], running[15:8],
                                        running[23:16], running[31:24]});
                    crc_sums++;
                end
                else
                begin
                    due_sums.push_back(running);
                    xor_sums++;
                end
                running = '0;
            end
        endfunction

        // Compare one accepted checksum with the oldest due one
        function void check_checksum(logic [31:0] actual);
            logic [31:0] due;
            if (due_sums.size() == 0)
            begin
                $error("checksum: unexpected result %h", actual);
                errors++;
                return;
            end
            due = due_sums.pop_front();
            sums_checked++;
            if (actual !== due)
            begin
                $error("checksum mismatch: expected %h, actual %h", due, actual);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return due_sums.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic long_hold_req;
    int   burst_left;
    int   words_sent;

    checksum_scoreboard sb = new();

    icx_cfg_if cfg_ch ();
    icx_in_if  in_ch ();
    icx_out_if out_ch ();

    image_checksum_xor_or_crc32 u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .image  (in_ch),
        .result (out_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Output side: ready on a changing pattern, with an occasional long hold
    initial
    begin
        int pat;
        int pat_left;
        int hold_left;
        pat = 0;
        pat_left = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold_left = 300;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready = 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat = $urandom_range(0, 3);
                    pat_left = $urandom_range(8, 80);
                end
                pat_left--;
                case (pat)
                    0:       out_ch.ready = 1'b1;
                    1:       out_ch.ready = 1'($urandom_range(0, 1));
                    2:       out_ch.ready = (pat_left % 4 != 0);
                    default: out_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check_checksum(out_ch.checksum);
        end
    end

    // Offer one word request; returns at the falling edge after acceptance
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt,
                             input logic lst);
        logic taken;
        if (burst_left == 0)
        begin
            // gap between bursts, sometimes none
            in_ch.valid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid = 1'b1;
        in_ch.data_word = w;
        in_ch.byte_count = cnt;
        in_ch.last_item = lst;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = in_ch.ready;
            if (taken)
                sb.note_word(w, cnt, lst);
            @(negedge clk);
        end
        words_sent++;
    endtask

    // Wait until every due checksum has come and the pipeline is empty
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Mode register write, only with the block drained
    task automatic write_mode(input mode_t m);
        logic taken;
        cfg_ch.valid = 1'b1;
        cfg_ch.checksum_mode = m;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = cfg_ch.ready;
            if (taken)
                sb.set_mode(m);
            @(negedge clk);
        end
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Well-formed images of random length, with some broken counts mixed in
    task automatic send_images(input int n_words);
        int          stop_at;
        int          len;
        logic [2:0]  cnt;
        logic        lst;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                lst = (i == len - 1);
                cnt = lst ? 3'($urandom_range(1, 4)) : 3'd4;
                if ($urandom_range(0, 99) < 10)
                    cnt = 3'($urandom_range(0, 7));
                send_word(pick_word(), cnt, lst);
            end
        end
    endtask

    // Stimulus
    initial
    begin
        mode_t phase_mode;
        rst_n = 1'b0;
        long_hold_req = 1'b0;
        burst_left = 0;
        words_sent = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.checksum_mode = MODE_XOR;
        in_ch.valid = 1'b0;
        in_ch.data_word = '0;
        in_ch.byte_count = '0;
        in_ch.last_item = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // XOR mode after reset: extremes, partial last, zero and oversize counts
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_word(32'h1234_5678, 3'd4, 1'b0);
        send_word(32'h0000_0000, 3'd4, 1'b0);
        send_word(32'hA5A5_A5A5, 3'd3, 1'b1);
        send_word(32'h0F0F_0F0F, 3'd0, 1'b0);
        send_word(32'h1111_1111, 3'd5, 1'b0);
        send_word(32'h2222_2222, 3'd6, 1'b0);
        send_word(32'h8000_0001, 3'd7, 1'b1);
        wait_drained();
        write_mode(MODE_CRC);

        // CRC mode: check string, empty image, oversize count, early partial
        send_word(32'h3433_3231, 3'd4, 1'b0);
        send_word(32'h3837_3635, 3'd4, 1'b0);
        send_word(32'h0000_0039, 3'd1, 1'b1);
        send_word(32'hDEAD_BEEF, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
        send_word(32'hCAFE_F00D, 3'd2, 1'b0);
        send_word(32'h0000_0000, 3'd4, 1'b1);

        // Mode switched in the middle of an image, both ways
        send_word(32'h0102_0304, 3'd4, 1'b0);
        send_word(32'h89AB_CDEF, 3'd4, 1'b0);
        wait_drained();
        write_mode(MODE_XOR);
        send_word(32'h0000_0001, 3'd4, 1'b0);
        send_word(32'h0000_FFFF, 3'd1, 1'b1);
        send_word(32'h7E7E_7E7E, 3'd4, 1'b0);
        wait_drained();
        write_mode(MODE_CRC);
        send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
        wait_drained();

        // Random phases, each in its own mode
        for (int ph = 0; ph < 8; ph++)
        begin
            phase_mode = (ph == 0) ? MODE_XOR : (ph == 1) ? MODE_CRC :
                         mode_t'($urandom_range(0, 1));
            write_mode(phase_mode);
            if (ph == 4)
            begin
                // long output hold-off while short images keep coming
                long_hold_req = 1'b1;
                for (int i = 0; i < 50; i++)
                    send_word(pick_word(), 3'd4, 1'b1);
            end
            send_images(130);
            wait_drained();
        end

        $display("Run covered %0d word requests and %0d checksums (%0d XOR, %0d CRC-32),",
                 sb.words_seen, sb.sums_checked, sb.xor_sums, sb.crc_sums);
        $display("with mid-image mode changes, odd byte counts and a long output stall.");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
